// ===== sv/pms_pkg.sv =====
// shared types and constants of the partitioned multi-stack
package pms_pkg;

  localparam int unsigned CAPACITY_DEF  = 16;
  localparam int unsigned STACK_SLOTS   = 16;
  localparam int unsigned LIST_LIMIT    = 16;
  localparam int unsigned ID_W          = 4;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned BEAT_W        = 4;
  localparam int unsigned NUM_STACKS_W  = 5;
  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam int unsigned CFG_ADDR_W    = 3;
  localparam int unsigned CFG_DATA_W    = 32;
  localparam int unsigned REG_IDX_W     = 1;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_NUM_STACKS = 1'd0;

  typedef enum logic [1:0] {
    REQ_PUSH = 2'd0,
    REQ_POP  = 2'd1,
    REQ_LIST = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_INVALID  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CMD_REPORT = 2'd0,
    CMD_PUSH   = 2'd1,
    CMD_READ   = 2'd2
  } cmd_kind_e;

  // one classified request on its way to the back end
  typedef struct packed {
    cmd_kind_e                 kind;
    status_e                   status;
    logic [BEAT_W-1:0]         beats_m1;
    logic signed [WORD_W-1:0]  value;
  } cmd_t;

endpackage

// ===== sv/pms_front.sv =====
// front end: stack bookkeeping, request classification, configuration
module pms_front #(
  parameter int unsigned Capacity = pms_pkg::CAPACITY_DEF,
  localparam int unsigned AddrW = $clog2(Capacity),
  localparam int unsigned CntW  = $clog2(Capacity + 1)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [pms_pkg::NUM_STACKS_W-1:0]   cfg_wdata_i,
  output logic [pms_pkg::NUM_STACKS_W-1:0]   num_stacks_o,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         req_type_i,
  input  logic [pms_pkg::ID_W-1:0]           stack_id_i,
  input  logic signed [pms_pkg::WORD_W-1:0]  push_value_i,
  output logic                               cmd_valid_o,
  input  logic                               cmd_ready_i,
  output pms_pkg::cmd_t                      cmd_o,
  output logic [AddrW-1:0]                   cmd_addr_o
);

  localparam int unsigned ProdW = CntW + pms_pkg::ID_W;

  logic [pms_pkg::NUM_STACKS_W-1:0] num_stacks_q, num_stacks_d;
  logic [CntW-1:0]                  region_q, region_d;
  logic [CntW-1:0]                  fill_q [pms_pkg::STACK_SLOTS];
  logic [CntW-1:0]                  region_tab [pms_pkg::STACK_SLOTS];

  logic [pms_pkg::NUM_STACKS_W-1:0] n_clamp;
  logic [CntW-1:0]                  cnt, cnt_m1, cnt_new;
  logic [ProdW-1:0]                 base, push_addr, top_addr;
  logic                             id_ok, accept, fill_we;

  // entries per stack for every stack count, settled at elaboration
  for (genvar g = 1; g <= pms_pkg::STACK_SLOTS; g++) begin : g_region
    localparam int unsigned Rs = Capacity / g;
    assign region_tab[g-1] = CntW'(Rs);
  end

  always_comb begin
    n_clamp = cfg_wdata_i;
    if (cfg_wdata_i == '0) begin
      n_clamp = pms_pkg::NUM_STACKS_W'(1);
    end else if (cfg_wdata_i > pms_pkg::NUM_STACKS_W'(pms_pkg::STACK_SLOTS)) begin
      n_clamp = pms_pkg::NUM_STACKS_W'(pms_pkg::STACK_SLOTS);
    end
  end

  assign num_stacks_d = cfg_we_i ? n_clamp : num_stacks_q;
  assign region_d     = cfg_we_i ? region_tab[pms_pkg::ID_W'(n_clamp - 1'b1)] : region_q;

  assign accept      = in_valid_i && cmd_ready_i;
  assign in_ready_o  = cmd_ready_i;
  assign cmd_valid_o = in_valid_i;

  assign id_ok     = {1'b0, stack_id_i} < num_stacks_q;
  assign cnt       = fill_q[stack_id_i];
  assign cnt_m1    = cnt - CntW'(1);
  assign base      = ProdW'(region_q * stack_id_i);
  assign push_addr = base + ProdW'(cnt);
  assign top_addr  = push_addr - ProdW'(1);

  always_comb begin
    cmd_o.kind     = pms_pkg::CMD_REPORT;
    cmd_o.status   = pms_pkg::ST_INVALID;
    cmd_o.beats_m1 = '0;
    cmd_o.value    = push_value_i;
    cmd_addr_o     = top_addr[AddrW-1:0];
    cnt_new        = cnt;
    fill_we        = 1'b0;
    priority if (!id_ok) begin
      cmd_o.status = pms_pkg::ST_INVALID;
    end else if (req_type_i == pms_pkg::REQ_PUSH) begin
      if (cnt >= region_q) begin
        cmd_o.status = pms_pkg::ST_OVERFLOW;
      end else begin
        cmd_o.kind   = pms_pkg::CMD_PUSH;
        cmd_o.status = pms_pkg::ST_OK;
        cmd_addr_o   = push_addr[AddrW-1:0];
        cnt_new      = cnt + CntW'(1);
        fill_we      = 1'b1;
      end
    end else if (req_type_i == pms_pkg::REQ_POP || req_type_i == pms_pkg::REQ_LIST) begin
      if (cnt == '0) begin
        cmd_o.status = pms_pkg::ST_EMPTY;
      end else if (req_type_i == pms_pkg::REQ_POP) begin
        cmd_o.kind   = pms_pkg::CMD_READ;
        cmd_o.status = pms_pkg::ST_OK;
        cnt_new      = cnt_m1;
        fill_we      = 1'b1;
      end else begin
        cmd_o.kind   = pms_pkg::CMD_READ;
        cmd_o.status = pms_pkg::ST_OK;
        if (32'(cnt) > pms_pkg::LIST_LIMIT) begin
          cmd_o.beats_m1 = pms_pkg::BEAT_W'(pms_pkg::LIST_LIMIT - 1);
        end else begin
          cmd_o.beats_m1 = pms_pkg::BEAT_W'(cnt_m1);
        end
      end
    end else begin
      // unused request code
      cmd_o.status = pms_pkg::ST_INVALID;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_stacks_q <= pms_pkg::NUM_STACKS_W'(1);
      region_q     <= CntW'(Capacity);
      for (int i = 0; i < pms_pkg::STACK_SLOTS; i++) begin
        fill_q[i] <= '0;
      end
    end else begin
      num_stacks_q <= num_stacks_d;
      region_q     <= region_d;
      if (cfg_we_i) begin
        for (int i = 0; i < pms_pkg::STACK_SLOTS; i++) begin
          fill_q[i] <= '0;
        end
      end else if (accept && fill_we) begin
        fill_q[stack_id_i] <= cnt_new;
      end
    end
  end

  assign num_stacks_o = num_stacks_q;

endmodule

// ===== sv/pms_queue.sv =====
// small first-in first-out queue between front and back end
module pms_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = pms_pkg::QUEUE_DEPTH,
  localparam int unsigned PtrW = $clog2(Depth),
  localparam int unsigned CntW = $clog2(Depth + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [Width-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [Width-1:0] pop_data_o
);

  logic [Width-1:0] slot_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign push_ready_o = count_q != CntW'(Depth);
  assign pop_valid_o  = count_q != '0;
  assign pop_data_o   = slot_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== sv/pms_back.sv =====
// back end: word memory, list walk and result registers
module pms_back #(
  parameter int unsigned Capacity = pms_pkg::CAPACITY_DEF,
  localparam int unsigned AddrW = $clog2(Capacity)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cmd_valid_i,
  output logic                               cmd_ready_o,
  input  pms_pkg::cmd_t                      cmd_i,
  input  logic [AddrW-1:0]                   cmd_addr_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [1:0]                         status_o,
  output logic signed [pms_pkg::WORD_W-1:0]  data_out_o,
  output logic                               last_o
);

  logic [pms_pkg::WORD_W-1:0] word_mem [Capacity];
  logic [pms_pkg::WORD_W-1:0] rdata_q;
  logic [pms_pkg::BEAT_W-1:0] walk_q, walk_d;

  logic                       beat_valid_q, beat_last_q, beat_mem_q;
  pms_pkg::status_e           beat_status_q;
  logic                       out_valid_q, out_last_q;
  pms_pkg::status_e           out_status_q;
  logic [pms_pkg::WORD_W-1:0] out_data_q;

  logic             issue, beat_move, cmd_last;
  logic [AddrW-1:0] addr;

  assign beat_move   = beat_valid_q && (!out_valid_q || out_ready_i);
  assign issue       = cmd_valid_i && (!beat_valid_q || beat_move);
  assign cmd_last    = walk_q == cmd_i.beats_m1;
  assign cmd_ready_o = issue && cmd_last;
  assign addr        = cmd_addr_i - AddrW'(walk_q);

  always_comb begin
    walk_d = walk_q;
    if (issue) begin
      walk_d = cmd_last ? '0 : walk_q + pms_pkg::BEAT_W'(1);
    end
  end

  // memory: one write or one read per cycle, read data registered
  always_ff @(posedge clk_i) begin
    if (issue && cmd_i.kind == pms_pkg::CMD_PUSH) begin
      word_mem[addr] <= cmd_i.value;
    end
    if (issue && cmd_i.kind == pms_pkg::CMD_READ) begin
      rdata_q <= word_mem[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_q       <= '0;
      beat_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      walk_q <= walk_d;
      if (issue) begin
        beat_valid_q <= 1'b1;
      end else if (beat_move) begin
        beat_valid_q <= 1'b0;
      end
      if (beat_move) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      beat_status_q <= cmd_i.status;
      beat_last_q   <= cmd_last;
      beat_mem_q    <= cmd_i.kind == pms_pkg::CMD_READ;
    end
    if (beat_move) begin
      out_status_q <= beat_status_q;
      out_last_q   <= beat_last_q;
      out_data_q   <= beat_mem_q ? rdata_q : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign data_out_o  = out_data_q;
  assign last_o      = out_last_q;

  a_walk_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue && cmd_last |=> walk_q == '0)
    else $error("walk counter not cleared after last beat");

  a_walk_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue && !cmd_last |=> walk_q == $past(walk_q) + pms_pkg::BEAT_W'(1))
    else $error("walk counter did not advance");

  a_single_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue && cmd_i.kind != pms_pkg::CMD_READ |-> walk_q == '0 && cmd_last)
    else $error("push or report spans more than one beat");

  a_rdata_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat_valid_q && !beat_move |=> beat_valid_q && $stable(rdata_q))
    else $error("read data changed under a stalled beat");

endmodule

// ===== sv/partitioned_multi_stack.sv =====
// top level of the partitioned multi-stack
// Several LIFO stacks share one store of Capacity 32-bit words, split into
// num_stacks equal regions of Capacity / num_stacks entries (num_stacks is
// register 0 at byte address 0; writing it empties every stack, 0 is taken
// as 1 and values above 16 as 16). Each request gives one result, except a
// list, which gives the stack's words top first (at most 16) with last set on
// the final one. The front end tracks fill counts and classifies each request
// in the cycle it is accepted, so it takes one item per cycle while its
// two-entry queue has room. The back end owns the single-port word memory and
// gives one result per push, pop, error or listed word, and can take a
// new beat while earlier ones are in flight. The memory read is registered:
// a result passes the beat and then the output registers after its item heads
// the queue, later only when earlier results or the result side hold it back.
// Unused words need no clearing at reset; there is no clearing pass.
module partitioned_multi_stack #(
  parameter int unsigned Capacity = pms_pkg::CAPACITY_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pms_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [pms_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [pms_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                pready,
  // request channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          req_type_i,
  input  logic [pms_pkg::ID_W-1:0]            stack_id_i,
  input  logic signed [pms_pkg::WORD_W-1:0]   push_value_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [1:0]                          status_o,
  output logic signed [pms_pkg::WORD_W-1:0]   data_out_o,
  output logic                                last_o
);

  localparam int unsigned AddrW = $clog2(Capacity);
  localparam int unsigned CmdW  = $bits(pms_pkg::cmd_t) + AddrW;

  logic                              cfg_sel, cfg_we;
  logic [pms_pkg::NUM_STACKS_W-1:0]  num_stacks;

  logic                f_valid, f_ready, b_valid, b_ready;
  pms_pkg::cmd_t       f_cmd, b_cmd;
  logic [AddrW-1:0]    f_addr, b_addr;
  logic [CmdW-1:0]     f_word, b_word;

  // register decode: word index taken from the upper address bits
  assign cfg_sel = paddr[pms_pkg::CFG_ADDR_W-1:2] == pms_pkg::REG_NUM_STACKS;
  assign cfg_we  = psel && penable && pwrite && cfg_sel;
  assign pready  = 1'b1;
  assign prdata  = cfg_sel ? pms_pkg::CFG_DATA_W'(num_stacks) : '0;

  pms_front #(
    .Capacity (Capacity)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (pwdata[pms_pkg::NUM_STACKS_W-1:0]),
    .num_stacks_o (num_stacks),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .stack_id_i   (stack_id_i),
    .push_value_i (push_value_i),
    .cmd_valid_o  (f_valid),
    .cmd_ready_i  (f_ready),
    .cmd_o        (f_cmd),
    .cmd_addr_o   (f_addr)
  );

  // classified requests wait here so either side can stall alone
  assign f_word = {f_cmd, f_addr};
  assign b_cmd  = b_word[CmdW-1:AddrW];
  assign b_addr = b_word[AddrW-1:0];

  pms_queue #(
    .Width (CmdW),
    .Depth (pms_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_word),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (b_word)
  );

  pms_back #(
    .Capacity (Capacity)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (b_valid),
    .cmd_ready_o (b_ready),
    .cmd_i       (b_cmd),
    .cmd_addr_i  (b_addr),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .data_out_o  (data_out_o),
    .last_o      (last_o)
  );

endmodule

// ===== verif/partitioned_multi_stack_test.sv =====
`timescale 1ns / 1ps
// self-checking testbench of the partitioned multi-stack with a predicting scoreboard
module partitioned_multi_stack_test;

  // sizes of the block under test and of the run
  localparam int unsigned CAP          = pms_pkg::CAPACITY_DEF;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned NUM_PHASES   = 9;
  localparam int unsigned PHASE_ITEMS  = 40;

  // request code that the package leaves unnamed, must come back as invalid
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // byte addresses of the configuration port: one register per 32-bit word
  localparam int unsigned REG_SPARE_IDX = 1;  // no register here, writes are dropped
  localparam logic [pms_pkg::CFG_ADDR_W-1:0] ADDR_NUM_STACKS =
    pms_pkg::CFG_ADDR_W'(4 * pms_pkg::REG_NUM_STACKS);
  localparam logic [pms_pkg::CFG_ADDR_W-1:0] ADDR_SPARE =
    pms_pkg::CFG_ADDR_W'(4 * REG_SPARE_IDX);

  // ---------------------------------------------------------------------------
  // scoreboard: mirrors the stack state and keeps the results still owed
  // ---------------------------------------------------------------------------
  class stack_scoreboard;
    typedef struct packed {
      pms_pkg::status_e                  st;
      logic signed [pms_pkg::WORD_W-1:0] data;
      logic                              fin;
    } outcome_t;

    outcome_t                          owed_q[$];
    logic signed [pms_pkg::WORD_W-1:0] words[CAP];
    int unsigned                       fill[pms_pkg::STACK_SLOTS];
    int unsigned                       stack_count;
    int unsigned                       region_len;
    // bookkeeping for the summary
    int unsigned mismatches, requests, results, overflows, empties, invalids;
    int unsigned longest_list, settings;

    function new();
      stack_count = 1;
      region_len  = CAP;
      foreach (fill[i]) fill[i] = 0;
      foreach (words[i]) words[i] = '0;
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    // register write: clamp to 1..16, resize the regions, empty every stack
    function void apply_stack_count(logic [pms_pkg::CFG_DATA_W-1:0] raw);
      int unsigned n;
      n = raw[pms_pkg::NUM_STACKS_W-1:0];
      if (n == 0) n = 1;
      if (n > pms_pkg::STACK_SLOTS) n = pms_pkg::STACK_SLOTS;
      stack_count = n;
      region_len  = CAP / n;
      foreach (fill[i]) fill[i] = 0;
      settings++;
    endfunction

    function void owe(pms_pkg::status_e st, logic signed [pms_pkg::WORD_W-1:0] data,
                      logic fin);
      outcome_t o;
      o.st   = st;
      o.data = data;
      o.fin  = fin;
      owed_q.push_back(o);
    endfunction

    // accepted request: update the mirror and queue what the block must answer
    function void note_request(logic [1:0] kind, logic [pms_pkg::ID_W-1:0] id,
                               logic signed [pms_pkg::WORD_W-1:0] value);
      int unsigned base, cnt, n, addr;
      requests++;
      if (id >= stack_count || kind == REQ_UNUSED) begin
        invalids++;
        owe(pms_pkg::ST_INVALID, '0, 1'b1);
        return;
      end
      base = region_len * id;
      cnt  = fill[id];
      if (kind == pms_pkg::REQ_PUSH) begin
        if (cnt >= region_len) begin
          overflows++;
          owe(pms_pkg::ST_OVERFLOW, '0, 1'b1);
          return;
        end
        if (base + cnt < CAP) words[base + cnt] = value;
        fill[id] = cnt + 1;
        owe(pms_pkg::ST_OK, '0, 1'b1);
        return;
      end
      if (cnt == 0) begin
        empties++;
        owe(pms_pkg::ST_EMPTY, '0, 1'b1);
        return;
      end
      if (kind == pms_pkg::REQ_POP) begin
        addr = base + cnt - 1;
        fill[id] = cnt - 1;
        owe(pms_pkg::ST_OK, (addr < CAP) ? words[addr] : '0, 1'b1);
        return;
      end
      // list: top first, capped at the list limit
      n = (cnt > pms_pkg::LIST_LIMIT) ? pms_pkg::LIST_LIMIT : cnt;
      if (n > longest_list) longest_list = n;
      for (int unsigned i = 0; i < n; i++) begin
        addr = base + cnt - 1 - i;
        owe(pms_pkg::ST_OK, (addr < CAP) ? words[addr] : '0, (i + 1 == n));
      end
    endfunction

    // accepted result: compare field by field with the oldest one owed
    function void check_result(logic [1:0] st, logic signed [pms_pkg::WORD_W-1:0] data,
                               logic fin);
      outcome_t o;
      results++;
      if (owed_q.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing owed: status %0d data %0d last %0d",
                 $time, st, data, fin);
        return;
      end
      o = owed_q.pop_front();
      if (st !== o.st) begin
        mismatches++;
        $display("%0t: status expected %0d actual %0d", $time, o.st, st);
      end
      if (data !== o.data) begin
        mismatches++;
        $display("%0t: data_out expected %0d actual %0d", $time, o.data, data);
      end
      if (fin !== o.fin) begin
        mismatches++;
        $display("%0t: last expected %0d actual %0d", $time, o.fin, fin);
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // block under test and its signals
  // ---------------------------------------------------------------------------
  logic                              clk_i = 1'b0;
  logic                              rst_ni;
  logic                              psel, penable, pwrite;
  logic [pms_pkg::CFG_ADDR_W-1:0]    paddr;
  logic [pms_pkg::CFG_DATA_W-1:0]    pwdata;
  logic [pms_pkg::CFG_DATA_W-1:0]    prdata;
  logic                              pready;
  logic                              in_valid_i, in_ready_o;
  logic [1:0]                        req_type_i;
  logic [pms_pkg::ID_W-1:0]          stack_id_i;
  logic signed [pms_pkg::WORD_W-1:0] push_value_i;
  logic                              out_valid_o, out_ready_i;
  logic [1:0]                        status_o;
  logic signed [pms_pkg::WORD_W-1:0] data_out_o;
  logic                              last_o;

  stack_scoreboard sb;
  int unsigned     cycle_count = 0;
  bit              quiet = 1'b0;      // no idling on either side when set
  bit              long_hold = 1'b0;  // asks the result side for one long stall

  partitioned_multi_stack uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .stack_id_i   (stack_id_i),
    .push_value_i (push_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .data_out_o   (data_out_o),
    .last_o       (last_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog: a correct run stays far below this
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_count, sb.pending());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // results are sampled at the rising edge, where the handshake counts
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(status_o, data_out_o, last_o);
  end

  // result side: random stall bursts, plus one long stall on request
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        // counted here so the request side keeps offering items meanwhile
        out_ready_i = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        long_hold = 1'b0;
      end
      if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ready_i = 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // drivers: everything changes at the falling edge
  // ---------------------------------------------------------------------------

  // write in a setup phase then an access phase, the register takes it when pready is high
  task automatic write_register(logic [pms_pkg::CFG_ADDR_W-1:0] addr,
                                logic [pms_pkg::CFG_DATA_W-1:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == ADDR_NUM_STACKS) sb.apply_stack_count(value);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // stack count with random junk above the 5 bits the block looks at
  task automatic set_stack_count(int unsigned n);
    write_register(ADDR_NUM_STACKS, {$urandom_range(0, 1) ? 27'($urandom) : 27'd0, 5'(n)});
  endtask

  // offer one item and hold it until taken; valid stays high into the next item unless a random pause drops it
  task automatic send_request(logic [1:0] kind, logic [pms_pkg::ID_W-1:0] id,
                              logic signed [pms_pkg::WORD_W-1:0] value);
    in_valid_i   = 1'b1;
    req_type_i   = kind;
    stack_id_i   = id;
    push_value_i = value;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(kind, id, value);
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
  endtask

  // idle the request side until every owed result is back, then a short pause
  task automatic drain();
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // mostly valid stack numbers, some out of range; push share sets how deep stacks grow
  task automatic random_request(int unsigned push_pct);
    int unsigned                       r;
    logic [1:0]                        kind;
    logic [pms_pkg::ID_W-1:0]          id;
    logic signed [pms_pkg::WORD_W-1:0] value;
    r = $urandom_range(0, 99);
    if (r < push_pct) kind = pms_pkg::REQ_PUSH;
    else if (r < push_pct + (100 - push_pct) / 2) kind = pms_pkg::REQ_POP;
    else if (r < 95) kind = pms_pkg::REQ_LIST;
    else kind = REQ_UNUSED;
    if ($urandom_range(0, 9) != 0) begin
      id = pms_pkg::ID_W'($urandom_range(0, sb.stack_count - 1));
    end else begin
      id = pms_pkg::ID_W'($urandom_range(0, pms_pkg::STACK_SLOTS - 1));
    end
    case ($urandom_range(0, 9))
      0:       value = 32'sh8000_0000;
      1:       value = 32'sh7fff_ffff;
      default: value = $urandom;
    endcase
    send_request(kind, id, value);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  int unsigned phase_stacks[NUM_PHASES] = '{3, 1, 16, 2, 5, 0, 31, 7, 4};
  int unsigned phase_push[NUM_PHASES]   = '{45, 60, 45, 50, 45, 55, 45, 40, 50};

  initial begin
    sb           = new();
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid_i   = 1'b0;
    req_type_i   = pms_pkg::REQ_PUSH;
    stack_id_i   = '0;
    push_value_i = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // one stack of the whole array after reset: extremes, lifo order, empty cases
    send_request(pms_pkg::REQ_PUSH, 4'd0, 32'sh7fff_ffff);
    send_request(pms_pkg::REQ_PUSH, 4'd0, 32'sh8000_0000);
    send_request(pms_pkg::REQ_PUSH, 4'd0, 32'sd0);
    send_request(pms_pkg::REQ_PUSH, 4'd0, -32'sd1);
    send_request(pms_pkg::REQ_LIST, 4'd0, 32'sd0);
    send_request(pms_pkg::REQ_POP, 4'd0, 32'sd0);
    send_request(pms_pkg::REQ_POP, 4'd0, 32'sd0);
    send_request(pms_pkg::REQ_LIST, 4'd0, -32'sd1);
    send_request(pms_pkg::REQ_POP, 4'd0, 32'sd0);
    send_request(pms_pkg::REQ_POP, 4'd0, 32'sd0);
    send_request(pms_pkg::REQ_POP, 4'd0, 32'sd0);       // underflow
    send_request(pms_pkg::REQ_LIST, 4'd0, 32'sd0);      // empty list
    send_request(REQ_UNUSED, 4'd0, 32'sd7);             // unused request code
    send_request(pms_pkg::REQ_PUSH, 4'd15, 32'sd9);     // stack number out of range
    drain();

    // one entry per stack: overflow on the second push
    set_stack_count(16);
    send_request(pms_pkg::REQ_PUSH, 4'd15, 32'sh5a5a_5a5a);
    send_request(pms_pkg::REQ_PUSH, 4'd15, 32'sh0f0f_0f0f);
    send_request(pms_pkg::REQ_LIST, 4'd15, 32'sd0);
    send_request(pms_pkg::REQ_POP, 4'd15, 32'sd0);
    send_request(pms_pkg::REQ_POP, 4'd15, 32'sd0);
    send_request(pms_pkg::REQ_POP, 4'd0, 32'sd0);
    send_request(pms_pkg::REQ_LIST, 4'd7, 32'sd0);
    drain();

    // random phases over several stack counts, including the clamped ones
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == 3) write_register(ADDR_SPARE, 32'd9);  // must leave the layout alone
      set_stack_count(phase_stacks[p]);
      if (p == 1) long_hold = 1'b1;  // fill the block while results are held off
      if (p >= NUM_PHASES - 2) quiet = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) random_request(phase_push[p]);
      drain();
    end

    repeat (20) @(negedge clk_i);
    $display("%0d requests, %0d results, %0d stack settings, lists up to %0d words",
             sb.requests, sb.results, sb.settings + 1, sb.longest_list);
    $display("%0d overflows, %0d empty reports, %0d invalid requests, %0d mismatches",
             sb.overflows, sb.empties, sb.invalids, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/pms_pkg.sv
sv/pms_front.sv
sv/pms_queue.sv
sv/pms_back.sv
sv/partitioned_multi_stack.sv
verif/partitioned_multi_stack_test.sv
